// ===== rtl/plce_pkg.sv =====
// Shared types and constants for the particle cell-list engine.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package plce_pkg;

	// Table geometry.
	localparam int AXIS_BINS = 16;
	localparam int AXIS_W    = 4;
	localparam int NUM_BINS  = 4096;
	localparam int BIN_W     = 12;
	localparam int BIN_CAP   = 8;
	localparam int SLOT_W    = 3;
	localparam int FILL_W    = 4;
	localparam int MAX_TAGS  = 1024;
	localparam int TAG_W     = 10;
	localparam int MAX_RES   = 64;
	localparam int CNT_W     = 7;
	localparam int HOME_W    = BIN_W + 1;
	localparam int SADDR_W   = BIN_W + SLOT_W;

	// Action codes.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOTAG = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_BINS_X   = 3'd0;
	localparam logic [2:0] REG_BINS_Y   = 3'd1;
	localparam logic [2:0] REG_BINS_Z   = 3'd2;
	localparam logic [2:0] REG_PERIODIC = 3'd3;
	localparam logic [2:0] REG_INV_X    = 3'd4;
	localparam logic [2:0] REG_INV_Y    = 3'd5;
	localparam logic [2:0] REG_INV_Z    = 3'd6;

	typedef struct packed {
		logic [1:0]         action;
		logic [TAG_W-1:0]   tag_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin_index;
		logic             done_ok;
		logic [TAG_W-1:0] neighbour_tag;
		logic             tag_present;
		logic             last_item;
		logic [1:0]       status;
	} out_item_t;

	// One axis of the position-to-bin mapping.
	typedef struct packed {
		logic               valid;
		logic [1:0]         axis;
		logic signed [31:0] pos;
		logic [31:0]        inv;
		logic [4:0]         nbins;
		logic               periodic;
	} ax_req_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        axis;
		logic [AXIS_W-1:0] bin;
	} ax_res_t;

	// Accesses to the three table memories.
	typedef struct packed {
		logic               slot_re;
		logic               slot_we;
		logic [SADDR_W-1:0] slot_addr;
		logic [TAG_W-1:0]   slot_wdata;
		logic               fill_re;
		logic               fill_we;
		logic [BIN_W-1:0]   fill_addr;
		logic [FILL_W-1:0]  fill_wdata;
		logic               home_re;
		logic               home_we;
		logic [TAG_W-1:0]   home_addr;
		logic [HOME_W-1:0]  home_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [TAG_W-1:0]  slot_rdata;
		logic [FILL_W-1:0] fill_rdata;
		logic [HOME_W-1:0] home_rdata;
		logic              busy;
	} mem_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MAP, S_BIN1, S_BIN2, S_HOME, S_HOME_CHK,
		S_DFILL, S_DSRD, S_DSCHK, S_DMOVE, S_IFILL, S_IFCHK,
		S_DIVX, S_DIVY, S_QB1, S_QB2, S_QFRD, S_QFCHK, S_QSRD, S_QSCHK,
		S_QNEXT, S_QEND, S_CLR, S_RESP
	} state_t;

endpackage

// ===== rtl/particle_cell_list_engine.sv =====
// Particle cell-list engine: a 3-D bin table of particle tags with insert, remove,
// neighbour query and clear. Each action takes one request beat and gives one result
// beat, except a query, which gives one beat per neighbouring tag (at most 64, the
// last one marked). All state lives in three single-port memories (bin slots, bin
// fill counts, tag homes) walked by one sequencer, one access per cycle, so the
// latency follows the memory traffic. An insert or a remove of a stored tag searches
// the slots of its home bin; a query first splits the home bin index into its axis
// bins by repeated subtraction, then reads the fill count and the slots of each
// neighbour bin inside the grid; a stalled result beat makes the walk wait. One
// item is worked at a time; the next request is taken once the last result beat is
// in the output register. After reset, after a clear and after any bin-count write,
// a clearing pass runs during which no request is taken (configuration writes are
// taken as usual).
// Depends on plce_pkg, plce_axis, plce_store and plce_ctrl.
module particle_cell_list_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  plce_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output plce_pkg::out_item_t rsp,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	plce_pkg::ax_req_t  ax_req;
	plce_pkg::ax_res_t  ax_res;
	plce_pkg::mem_req_t mreq;
	plce_pkg::mem_rsp_t mrsp;
	logic               wipe;

	plce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ax_req    (ax_req),
		.ax_res    (ax_res),
		.wipe      (wipe),
		.mreq      (mreq),
		.mrsp      (mrsp)
	);

	plce_axis u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ax_req),
		.res    (ax_res)
	);

	plce_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wipe   (wipe),
		.req    (mreq),
		.rsp    (mrsp)
	);

endmodule

// ===== rtl/plce_axis.sv =====
// Two-stage position-to-bin mapper for one axis per beat.
// Depends on plce_pkg for the request and result types.
module plce_axis (
	input  logic               clk,
	input  logic               arst_n,
	input  plce_pkg::ax_req_t  req,
	output plce_pkg::ax_res_t  res
);

	logic signed [64:0] prod_s1;
	logic               valid_s1;
	logic [1:0]         axis_s1;
	logic [4:0]         nbins_s1;
	logic               per_s1;
	logic signed [65:0] sum;
	logic signed [33:0] bfl;
	logic [plce_pkg::AXIS_W-1:0] bclamp;
	logic               valid_s2;
	logic [1:0]         axis_s2;
	logic [plce_pkg::AXIS_W-1:0] bin_s2;

	// Stage one: the Q32.32 product of position and inverse bin width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= req.pos * $signed({1'b0, req.inv});
		axis_s1  <= req.axis;
		nbins_s1 <= req.nbins;
		per_s1   <= req.periodic;
	end

	// Stage two: add half the bin count, floor, wrap the top edge and clamp.
	always_comb begin
		sum = {prod_s1[64], prod_s1} + $signed({30'b0, nbins_s1, 31'b0});
		bfl = sum[65:32];
		if (per_s1 && bfl == $signed({29'b0, nbins_s1})) begin
			bclamp = '0;
		end else if (bfl[33]) begin
			bclamp = '0;
		end else if (bfl >= $signed({29'b0, nbins_s1})) begin
			bclamp = plce_pkg::AXIS_W'(nbins_s1 - 5'd1);
		end else begin
			bclamp = bfl[plce_pkg::AXIS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		axis_s2 <= axis_s1;
		bin_s2  <= bclamp;
	end

	assign res.valid = valid_s2;
	assign res.axis  = axis_s2;
	assign res.bin   = bin_s2;

endmodule

// ===== rtl/plce_store.sv =====
// Table memories: bin slots, bin fill counts and tag homes, plus the clearing pass.
// Depends on plce_pkg for the access types and table sizes.
module plce_store (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wipe,
	input  plce_pkg::mem_req_t req,
	output plce_pkg::mem_rsp_t rsp
);

	logic [plce_pkg::TAG_W-1:0]  slot_mem [plce_pkg::NUM_BINS*plce_pkg::BIN_CAP];
	logic [plce_pkg::FILL_W-1:0] fill_mem [plce_pkg::NUM_BINS];
	logic [plce_pkg::HOME_W-1:0] home_mem [plce_pkg::MAX_TAGS];

	logic [plce_pkg::BIN_W-1:0]  clr_cnt_q;
	logic                        busy_q;
	logic [plce_pkg::TAG_W-1:0]  slot_rd_q;
	logic [plce_pkg::FILL_W-1:0] fill_rd_q;
	logic [plce_pkg::HOME_W-1:0] home_rd_q;

	// Clearing pass: one fill entry per cycle, plus one home entry while the count is below MAX_TAGS.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (wipe) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == plce_pkg::BIN_W'(plce_pkg::NUM_BINS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Slot memory; its contents are never cleared.
	always_ff @(posedge clk) begin
		if (req.slot_we) begin
			slot_mem[req.slot_addr] <= req.slot_wdata;
		end
		if (req.slot_re) begin
			slot_rd_q <= slot_mem[req.slot_addr];
		end
	end

	// Fill memory.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			fill_mem[clr_cnt_q] <= '0;
		end else if (req.fill_we) begin
			fill_mem[req.fill_addr] <= req.fill_wdata;
		end
		if (req.fill_re) begin
			fill_rd_q <= fill_mem[req.fill_addr];
		end
	end

	// Home memory.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (clr_cnt_q < plce_pkg::BIN_W'(plce_pkg::MAX_TAGS)) begin
				home_mem[clr_cnt_q[plce_pkg::TAG_W-1:0]] <= '0;
			end
		end else if (req.home_we) begin
			home_mem[req.home_addr] <= req.home_wdata;
		end
		if (req.home_re) begin
			home_rd_q <= home_mem[req.home_addr];
		end
	end

	assign rsp.slot_rdata = slot_rd_q;
	assign rsp.fill_rdata = fill_rd_q;
	assign rsp.home_rdata = home_rd_q;
	assign rsp.busy       = busy_q;

endmodule

// ===== rtl/plce_ctrl.sv =====
// Sequencer of the cell-list engine: registers, handshakes and the per-action walk.
// Depends on plce_pkg; drives plce_axis and plce_store.
module plce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  plce_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output plce_pkg::out_item_t rsp,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output plce_pkg::ax_req_t   ax_req,
	input  plce_pkg::ax_res_t   ax_res,
	output logic                wipe,
	output plce_pkg::mem_req_t  mreq,
	input  plce_pkg::mem_rsp_t  mrsp
);

	localparam int AW = plce_pkg::AXIS_W;
	localparam int BW = plce_pkg::BIN_W;
	localparam int TW = plce_pkg::TAG_W;
	localparam int FW = plce_pkg::FILL_W;

	plce_pkg::state_t    state_q, state_d;
	logic [4:0]          bins_q [3];
	logic [2:0]          per_q;
	logic [31:0]         inv_q [3];
	logic [4:0]          nx, ny, nz;
	logic [8:0]          nynz_q;

	logic [1:0]          op_q;
	logic [TW-1:0]       tag_q;
	logic signed [31:0]  pos_q [3];
	logic [1:0]          ax_cnt_q;
	logic [AW-1:0]       bx_q, by_q, bz_q;
	logic [7:0]          t_q;
	logic [BW-1:0]       bin_q, home_q, r_q;
	logic [AW-1:0]       hx_q, hy_q, hz_q;
	logic [FW-1:0]       f_q, si_q;
	logic [1:0]          dx_q, dy_q, dz_q;
	logic [TW-1:0]       pend_q;
	logic                pend_v_q;
	logic [plce_pkg::CNT_W-1:0] cnt_q;
	logic                trunc_q;
	plce_pkg::out_item_t fin_q, rsp_q, emit_item;
	logic                rsp_valid_q, emit_en;

	logic                free, accept, scan_end, match, home_ok, last_off, cap_hit;
	logic [5:0]          qx, qy, qz;
	logic                in_range;
	logic [FW-1:0]       si_nxt;

	function automatic logic [4:0] eff_bins(input logic [4:0] n);
		logic [4:0] r;
		if (n == 5'd0) begin
			r = 5'd1;
		end else if (n > 5'(plce_pkg::AXIS_BINS)) begin
			r = 5'(plce_pkg::AXIS_BINS);
		end else begin
			r = n;
		end
		return r;
	endfunction

	assign nx = eff_bins(bins_q[0]);
	assign ny = eff_bins(bins_q[1]);
	assign nz = eff_bins(bins_q[2]);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q[0] <= 5'd16;
			bins_q[1] <= 5'd16;
			bins_q[2] <= 5'd16;
			per_q     <= 3'd7;
			inv_q[0]  <= 32'd1048576;
			inv_q[1]  <= 32'd1048576;
			inv_q[2]  <= 32'd1048576;
		end else if (cfg_we) begin
			case (cfg_index)
				plce_pkg::REG_BINS_X:   bins_q[0] <= cfg_data[4:0];
				plce_pkg::REG_BINS_Y:   bins_q[1] <= cfg_data[4:0];
				plce_pkg::REG_BINS_Z:   bins_q[2] <= cfg_data[4:0];
				plce_pkg::REG_PERIODIC: per_q     <= cfg_data[2:0];
				plce_pkg::REG_INV_X:    inv_q[0]  <= cfg_data;
				plce_pkg::REG_INV_Y:    inv_q[1]  <= cfg_data;
				plce_pkg::REG_INV_Z:    inv_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		nynz_q <= {4'b0, ny} * {4'b0, nz};
	end

	// Common decodes.
	assign free     = !rsp_valid_q || rsp_ready;
	assign accept   = req_valid && req_ready;
	assign scan_end = (si_q >= f_q) || (si_q >= FW'(plce_pkg::BIN_CAP));
	assign match    = (mrsp.slot_rdata == tag_q);
	assign home_ok  = mrsp.home_rdata[plce_pkg::HOME_W-1];
	assign last_off = (dx_q == 2'd2) && (dy_q == 2'd2) && (dz_q == 2'd2);
	assign cap_hit  = (cnt_q == plce_pkg::CNT_W'(plce_pkg::MAX_RES));
	assign si_nxt   = si_q + 1'b1;
	assign qx = {2'b0, hx_q} + {4'b0, dx_q} - 6'd1;
	assign qy = {2'b0, hy_q} + {4'b0, dy_q} - 6'd1;
	assign qz = {2'b0, hz_q} + {4'b0, dz_q} - 6'd1;
	assign in_range = !qx[5] && (qx[4:0] < nx) && !qy[5] && (qy[4:0] < ny)
		&& !qz[5] && (qz[4:0] < nz);
	assign req_ready = (state_q == plce_pkg::S_IDLE) && !mrsp.busy;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			plce_pkg::S_IDLE: begin
				if (accept) begin
					case (req.action)
						plce_pkg::ACT_INSERT: state_d = plce_pkg::S_MAP;
						plce_pkg::ACT_CLEAR:  state_d = plce_pkg::S_CLR;
						default:              state_d = plce_pkg::S_HOME;
					endcase
				end
			end
			plce_pkg::S_MAP: begin
				if (ax_res.valid && ax_res.axis == 2'd2) state_d = plce_pkg::S_BIN1;
			end
			plce_pkg::S_BIN1: state_d = plce_pkg::S_BIN2;
			plce_pkg::S_BIN2: state_d = plce_pkg::S_HOME;
			plce_pkg::S_HOME: state_d = plce_pkg::S_HOME_CHK;
			plce_pkg::S_HOME_CHK: begin
				if (op_q == plce_pkg::ACT_QUERY) begin
					state_d = home_ok ? plce_pkg::S_DIVX : plce_pkg::S_RESP;
				end else if (home_ok) begin
					state_d = plce_pkg::S_DFILL;
				end else begin
					state_d = (op_q == plce_pkg::ACT_REMOVE) ? plce_pkg::S_RESP
						: plce_pkg::S_IFILL;
				end
			end
			plce_pkg::S_DFILL: state_d = plce_pkg::S_DSRD;
			plce_pkg::S_DSRD: begin
				if (scan_end) begin
					state_d = (op_q == plce_pkg::ACT_REMOVE) ? plce_pkg::S_RESP
						: plce_pkg::S_IFILL;
				end else begin
					state_d = plce_pkg::S_DSCHK;
				end
			end
			plce_pkg::S_DSCHK: state_d = match ? plce_pkg::S_DMOVE : plce_pkg::S_DSRD;
			plce_pkg::S_DMOVE: begin
				state_d = (op_q == plce_pkg::ACT_REMOVE) ? plce_pkg::S_RESP
					: plce_pkg::S_IFILL;
			end
			plce_pkg::S_IFILL: state_d = plce_pkg::S_IFCHK;
			plce_pkg::S_IFCHK: state_d = plce_pkg::S_RESP;
			plce_pkg::S_DIVX: begin
				if (r_q < {3'b0, nynz_q}) state_d = plce_pkg::S_DIVY;
			end
			plce_pkg::S_DIVY: begin
				if (r_q < {7'b0, nz}) state_d = plce_pkg::S_QB1;
			end
			plce_pkg::S_QB1: state_d = in_range ? plce_pkg::S_QB2 : plce_pkg::S_QNEXT;
			plce_pkg::S_QB2: state_d = plce_pkg::S_QFRD;
			plce_pkg::S_QFRD: state_d = plce_pkg::S_QFCHK;
			plce_pkg::S_QFCHK: state_d = plce_pkg::S_QSRD;
			plce_pkg::S_QSRD: state_d = scan_end ? plce_pkg::S_QNEXT : plce_pkg::S_QSCHK;
			plce_pkg::S_QSCHK: begin
				if (match) begin
					state_d = plce_pkg::S_QSRD;
				end else if (cap_hit) begin
					state_d = plce_pkg::S_QEND;
				end else if (!pend_v_q || free) begin
					state_d = plce_pkg::S_QSRD;
				end
			end
			plce_pkg::S_QNEXT: state_d = last_off ? plce_pkg::S_QEND : plce_pkg::S_QB1;
			plce_pkg::S_QEND: begin
				if (free) state_d = plce_pkg::S_IDLE;
			end
			plce_pkg::S_CLR: state_d = plce_pkg::S_RESP;
			plce_pkg::S_RESP: begin
				if (free) state_d = plce_pkg::S_IDLE;
			end
			default: state_d = plce_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plce_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs: memory accesses, mapper requests, clearing and result beats.
	always_comb begin
		mreq          = '0;
		ax_req        = '0;
		wipe          = cfg_we && (cfg_index == plce_pkg::REG_BINS_X
			|| cfg_index == plce_pkg::REG_BINS_Y || cfg_index == plce_pkg::REG_BINS_Z);
		emit_en       = 1'b0;
		emit_item     = fin_q;
		ax_req.axis   = ax_cnt_q;
		ax_req.pos    = pos_q[0];
		ax_req.inv    = inv_q[0];
		ax_req.nbins  = nx;
		ax_req.periodic = per_q[0];
		case (ax_cnt_q)
			2'd1: begin
				ax_req.pos = pos_q[1]; ax_req.inv = inv_q[1];
				ax_req.nbins = ny; ax_req.periodic = per_q[1];
			end
			2'd2: begin
				ax_req.pos = pos_q[2]; ax_req.inv = inv_q[2];
				ax_req.nbins = nz; ax_req.periodic = per_q[2];
			end
			default: ;
		endcase
		case (state_q)
			plce_pkg::S_MAP: ax_req.valid = (ax_cnt_q != 2'd3);
			plce_pkg::S_HOME: begin
				mreq.home_re   = 1'b1;
				mreq.home_addr = tag_q;
			end
			plce_pkg::S_HOME_CHK: begin
				mreq.fill_re   = 1'b1;
				mreq.fill_addr = mrsp.home_rdata[BW-1:0];
			end
			plce_pkg::S_DSRD: begin
				mreq.slot_re   = !scan_end;
				mreq.slot_addr = {home_q, si_q[plce_pkg::SLOT_W-1:0]};
			end
			plce_pkg::S_DSCHK: begin
				mreq.slot_re   = match;
				mreq.slot_addr = {home_q, 3'(f_q - 1'b1)};
			end
			plce_pkg::S_DMOVE: begin
				mreq.slot_we    = 1'b1;
				mreq.slot_addr  = {home_q, si_q[plce_pkg::SLOT_W-1:0]};
				mreq.slot_wdata = mrsp.slot_rdata;
				mreq.fill_we    = 1'b1;
				mreq.fill_addr  = home_q;
				mreq.fill_wdata = f_q - 1'b1;
				mreq.home_we    = 1'b1;
				mreq.home_addr  = tag_q;
				mreq.home_wdata = '0;
			end
			plce_pkg::S_IFILL: begin
				mreq.fill_re   = 1'b1;
				mreq.fill_addr = bin_q;
			end
			plce_pkg::S_IFCHK: begin
				if (mrsp.fill_rdata < FW'(plce_pkg::BIN_CAP)) begin
					mreq.slot_we    = 1'b1;
					mreq.slot_addr  = {bin_q, mrsp.fill_rdata[plce_pkg::SLOT_W-1:0]};
					mreq.slot_wdata = tag_q;
					mreq.fill_we    = 1'b1;
					mreq.fill_addr  = bin_q;
					mreq.fill_wdata = mrsp.fill_rdata + 1'b1;
					mreq.home_we    = 1'b1;
					mreq.home_addr  = tag_q;
					mreq.home_wdata = {1'b1, bin_q};
				end
			end
			plce_pkg::S_QFRD: begin
				mreq.fill_re   = 1'b1;
				mreq.fill_addr = bin_q;
			end
			plce_pkg::S_QSRD: begin
				mreq.slot_re   = !scan_end;
				mreq.slot_addr = {bin_q, si_q[plce_pkg::SLOT_W-1:0]};
			end
			plce_pkg::S_QSCHK: begin
				emit_item = '{bin_index: home_q, done_ok: 1'b0, neighbour_tag: pend_q,
					tag_present: 1'b1, last_item: 1'b0, status: plce_pkg::ST_OK};
				emit_en = !match && !cap_hit && pend_v_q && free;
			end
			plce_pkg::S_QEND: begin
				emit_en = free;
				if (pend_v_q) begin
					emit_item = '{bin_index: home_q, done_ok: 1'b0, neighbour_tag: pend_q,
						tag_present: 1'b1, last_item: 1'b1,
						status: trunc_q ? plce_pkg::ST_TRUNC : plce_pkg::ST_OK};
				end else begin
					emit_item = '{bin_index: home_q, done_ok: 1'b0, neighbour_tag: '0,
						tag_present: 1'b0, last_item: 1'b1, status: plce_pkg::ST_OK};
				end
			end
			plce_pkg::S_CLR: wipe = 1'b1;
			plce_pkg::S_RESP: emit_en = free;
			default: ;
		endcase
	end

	// Datapath registers of the walk.
	always_ff @(posedge clk) begin
		case (state_q)
			plce_pkg::S_IDLE: begin
				if (accept) begin
					op_q     <= req.action;
					tag_q    <= req.tag_id;
					pos_q[0] <= req.pos_x;
					pos_q[1] <= req.pos_y;
					pos_q[2] <= req.pos_z;
					ax_cnt_q <= 2'd0;
				end
			end
			plce_pkg::S_MAP: begin
				if (ax_cnt_q != 2'd3) ax_cnt_q <= ax_cnt_q + 2'd1;
				if (ax_res.valid) begin
					case (ax_res.axis)
						2'd0:    bx_q <= ax_res.bin;
						2'd1:    by_q <= ax_res.bin;
						default: bz_q <= ax_res.bin;
					endcase
				end
			end
			plce_pkg::S_BIN1: t_q <= 8'({5'b0, bx_q} * {4'b0, ny} + {5'b0, by_q});
			plce_pkg::S_BIN2: bin_q <= BW'({4'b0, t_q} * {7'b0, nz} + {8'b0, bz_q});
			plce_pkg::S_HOME_CHK: begin
				home_q <= mrsp.home_rdata[BW-1:0];
				r_q    <= mrsp.home_rdata[BW-1:0];
				hx_q   <= '0;
				hy_q   <= '0;
				fin_q  <= '{bin_index: '0, done_ok: 1'b0, neighbour_tag: '0,
					tag_present: 1'b0, last_item: 1'b1, status: plce_pkg::ST_NOTAG};
			end
			plce_pkg::S_DFILL: begin
				f_q  <= mrsp.fill_rdata;
				si_q <= '0;
			end
			plce_pkg::S_DSCHK: begin
				if (!match) si_q <= si_nxt;
			end
			plce_pkg::S_DMOVE: begin
				fin_q <= '{bin_index: home_q, done_ok: 1'b1, neighbour_tag: '0,
					tag_present: 1'b0, last_item: 1'b1, status: plce_pkg::ST_OK};
			end
			plce_pkg::S_IFCHK: begin
				if (mrsp.fill_rdata < FW'(plce_pkg::BIN_CAP)) begin
					fin_q <= '{bin_index: bin_q, done_ok: 1'b1, neighbour_tag: '0,
						tag_present: 1'b0, last_item: 1'b1, status: plce_pkg::ST_OK};
				end else begin
					fin_q <= '{bin_index: bin_q, done_ok: 1'b0, neighbour_tag: '0,
						tag_present: 1'b0, last_item: 1'b1, status: plce_pkg::ST_FULL};
				end
			end
			plce_pkg::S_DIVX: begin
				if (r_q >= {3'b0, nynz_q}) begin
					r_q  <= r_q - {3'b0, nynz_q};
					hx_q <= hx_q + 1'b1;
				end
			end
			plce_pkg::S_DIVY: begin
				if (r_q >= {7'b0, nz}) begin
					r_q  <= r_q - {7'b0, nz};
					hy_q <= hy_q + 1'b1;
				end else begin
					hz_q     <= r_q[AW-1:0];
					dx_q     <= '0;
					dy_q     <= '0;
					dz_q     <= '0;
					cnt_q    <= '0;
					pend_v_q <= 1'b0;
					trunc_q  <= 1'b0;
				end
			end
			plce_pkg::S_QB1: t_q <= 8'({5'b0, qx[AW-1:0]} * {4'b0, ny} + {5'b0, qy[AW-1:0]});
			plce_pkg::S_QB2: bin_q <= BW'({4'b0, t_q} * {7'b0, nz} + {8'b0, qz[AW-1:0]});
			plce_pkg::S_QFCHK: begin
				f_q  <= mrsp.fill_rdata;
				si_q <= '0;
			end
			plce_pkg::S_QSCHK: begin
				if (match) begin
					si_q <= si_nxt;
				end else if (cap_hit) begin
					trunc_q <= 1'b1;
				end else if (!pend_v_q || free) begin
					pend_q   <= mrsp.slot_rdata;
					pend_v_q <= 1'b1;
					cnt_q    <= cnt_q + 1'b1;
					si_q     <= si_nxt;
				end
			end
			plce_pkg::S_QNEXT: begin
				if (dz_q != 2'd2) begin
					dz_q <= dz_q + 2'd1;
				end else begin
					dz_q <= '0;
					if (dy_q != 2'd2) begin
						dy_q <= dy_q + 2'd1;
					end else begin
						dy_q <= '0;
						dx_q <= dx_q + 2'd1;
					end
				end
			end
			plce_pkg::S_CLR: begin
				fin_q <= '{bin_index: '0, done_ok: 1'b0, neighbour_tag: '0,
					tag_present: 1'b0, last_item: 1'b1, status: plce_pkg::ST_OK};
			end
			default: ;
		endcase
	end

	// Output register: one result beat waits here while the walk goes on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) rsp_q <= emit_item;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/plce_checker.sv =====
// Port-level checks of the cell-list engine, bound to the top level.
// Depends on plce_pkg and on the ports of particle_cell_list_engine.
module plce_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input plce_pkg::out_item_t rsp,
	input logic                rsp_valid,
	input logic                rsp_ready
);

	// A waiting result beat holds until taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// One item at a time: no request is taken right after one was taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Only query neighbour beats may be non-final, and they carry a tag.
	a_mid_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_item |-> rsp.tag_present && !rsp.done_ok
			&& rsp.status == plce_pkg::ST_OK)
		else $error("malformed non-final result beat");

	// A success result is final and reports no error.
	a_ok_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.done_ok |-> rsp.last_item && !rsp.tag_present
			&& rsp.status == plce_pkg::ST_OK)
		else $error("malformed success result beat");

endmodule

bind particle_cell_list_engine plce_checker u_plce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp       (rsp),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready)
);

// ===== verif/tb.sv =====
// Self-checking testbench for particle_cell_list_engine: random and directed actions
// are checked beat by beat against a behavioral predictor of the bin table.
// Depends on plce_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 40000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	plce_pkg::in_item_t  req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	plce_pkg::out_item_t rsp;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	particle_cell_list_engine dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Mirror of the configuration and the bin table.
	logic [4:0]  bins_reg [3];
	logic [2:0]  wrap_mask;
	logic [31:0] inv_reg [3];
	logic [9:0]  slot_tag [plce_pkg::NUM_BINS][plce_pkg::BIN_CAP];
	int          bin_count [plce_pkg::NUM_BINS];
	int          tag_bin [plce_pkg::MAX_TAGS];
	bit          tag_stored [plce_pkg::MAX_TAGS];

	plce_pkg::in_item_t  pending_items [$];
	plce_pkg::out_item_t expected_beats [$];
	int        errors = 0;
	int        items_sent = 0;
	int        beats_seen = 0;
	int        truncated_lists = 0;
	int        full_bins = 0;
	bit        sender_bursty = 1'b0;
	int        stall_pct = 0;

	function automatic void empty_table();
		for (int b = 0; b < plce_pkg::NUM_BINS; b++) bin_count[b] = 0;
		for (int t = 0; t < plce_pkg::MAX_TAGS; t++) tag_stored[t] = 1'b0;
	endfunction

	function automatic int axis_count(int a);
		if (bins_reg[a] == 0) return 1;
		if (bins_reg[a] > plce_pkg::AXIS_BINS) return plce_pkg::AXIS_BINS;
		return bins_reg[a];
	endfunction

	// Exact floor(pos * inv + n / 2), top-edge wrap, then clamp.
	function automatic int axis_bin(logic signed [31:0] pos, logic [31:0] inv, int n, bit per);
		logic signed [71:0] acc;
		logic signed [71:0] half;
		acc = $signed({{40{pos[31]}}, pos}) * $signed({40'd0, inv});
		half = 72'(n);
		acc = (acc + (half <<< 31)) >>> 32;
		if (per && acc == n) acc = 0;
		if (acc < 0) return 0;
		if (acc >= n) return n - 1;
		return int'(acc);
	endfunction

	function automatic bit take_out(int tag, output int from);
		int b;
		from = 0;
		if (!tag_stored[tag]) return 1'b0;
		b = tag_bin[tag];
		for (int i = 0; i < bin_count[b] && i < plce_pkg::BIN_CAP; i++) begin
			if (slot_tag[b][i] == tag) begin
				slot_tag[b][i] = slot_tag[b][bin_count[b] - 1];
				bin_count[b]--;
				tag_stored[tag] = 1'b0;
				from = b;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic plce_pkg::out_item_t beat(int bin, bit ok, int tag, bit pres, bit last,
			logic [1:0] st);
		plce_pkg::out_item_t o;
		o.bin_index = plce_pkg::BIN_W'(bin);
		o.done_ok = ok;
		o.neighbour_tag = plce_pkg::TAG_W'(tag);
		o.tag_present = pres;
		o.last_item = last;
		o.status = st;
		return o;
	endfunction

	// Queue one expected result beat.
	function automatic void expect_beat(plce_pkg::out_item_t o);
		expected_beats = {expected_beats, o};
	endfunction

	// Apply one action to the mirror and queue the beats it must produce.
	function automatic void apply_action(plce_pkg::in_item_t it);
		int nx, ny, nz, bin, from, home, hx, hy, hz, cnt, b;
		bit trunc;
		plce_pkg::out_item_t list [$];
		nx = axis_count(0);
		ny = axis_count(1);
		nz = axis_count(2);
		case (it.action)
			plce_pkg::ACT_INSERT: begin
				bin = (axis_bin(it.pos_x, inv_reg[0], nx, wrap_mask[0]) * ny
					+ axis_bin(it.pos_y, inv_reg[1], ny, wrap_mask[1])) * nz
					+ axis_bin(it.pos_z, inv_reg[2], nz, wrap_mask[2]);
				void'(take_out(it.tag_id, from));
				if (bin_count[bin] >= plce_pkg::BIN_CAP) begin
					full_bins++;
					expect_beat(beat(bin, 0, 0, 0, 1, plce_pkg::ST_FULL));
				end else begin
					slot_tag[bin][bin_count[bin]] = it.tag_id;
					bin_count[bin]++;
					tag_bin[it.tag_id] = bin;
					tag_stored[it.tag_id] = 1'b1;
					expect_beat(beat(bin, 1, 0, 0, 1, plce_pkg::ST_OK));
				end
			end
			plce_pkg::ACT_REMOVE: begin
				if (take_out(it.tag_id, from))
					expect_beat(beat(from, 1, 0, 0, 1, plce_pkg::ST_OK));
				else
					expect_beat(beat(0, 0, 0, 0, 1, plce_pkg::ST_NOTAG));
			end
			plce_pkg::ACT_QUERY: begin
				if (!tag_stored[it.tag_id]) begin
					expect_beat(beat(0, 0, 0, 0, 1, plce_pkg::ST_NOTAG));
				end else begin
					home = tag_bin[it.tag_id];
					hx = home / (ny * nz);
					hy = (home / nz) % ny;
					hz = home % nz;
					cnt = 0;
					trunc = 1'b0;
					// Visit the surrounding bins x-major with no wrap.
					for (int x = hx - 1; x <= hx + 1; x++)
						for (int y = hy - 1; y <= hy + 1; y++)
							for (int z = hz - 1; z <= hz + 1; z++) begin
								if (x < 0 || x >= nx || y < 0 || y >= ny || z < 0 || z >= nz)
									continue;
								b = (x * ny + y) * nz + z;
								for (int i = 0; i < bin_count[b]; i++) begin
									if (slot_tag[b][i] == it.tag_id) continue;
									if (cnt >= plce_pkg::MAX_RES) begin
										trunc = 1'b1;
										continue;
									end
									list = {list, beat(home, 0, slot_tag[b][i], 1, 0,
										plce_pkg::ST_OK)};
									cnt++;
								end
							end
					if (cnt == 0) begin
						list = {list, beat(home, 0, 0, 0, 1, plce_pkg::ST_OK)};
					end else begin
						list[cnt - 1].last_item = 1'b1;
						if (trunc) begin
							list[cnt - 1].status = plce_pkg::ST_TRUNC;
							truncated_lists++;
						end
					end
					expected_beats = {expected_beats, list};
				end
			end
			default: begin
				empty_table();
				expect_beat(beat(0, 0, 0, 0, 1, plce_pkg::ST_OK));
			end
		endcase
	endfunction

	// Request driver: items back to back, or in bursts with random gaps when bursty.
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				apply_action(req);
				items_sent++;
			end
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
					if (sender_bursty && --burst_left <= 0) begin
						burst_left = $urandom_range(1, 8);
						gap_left = $urandom_range(1, 7);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Result monitor with its own stall pattern.
	always @(posedge clk or negedge arst_n) begin
		plce_pkg::out_item_t e;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				beats_seen++;
				if (expected_beats.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_beats.pop_front();
					check_field("bin_index", e.bin_index, rsp.bin_index);
					check_field("done_ok", e.done_ok, rsp.done_ok);
					check_field("neighbour_tag", e.neighbour_tag, rsp.neighbour_tag);
					check_field("tag_present", e.tag_present, rsp.tag_present);
					check_field("last_item", e.last_item, rsp.last_item);
					check_field("status", e.status, rsp.status);
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog on cycles with no beat moving on either side.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d beats outstanding", expected_beats.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_items.size() > 0 || req_valid || expected_beats.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= plce_pkg::REG_BINS_Z) begin
			bins_reg[idx] = val[4:0];
			empty_table();
		end else if (idx == plce_pkg::REG_PERIODIC) begin
			wrap_mask = val[2:0];
		end else if (idx <= plce_pkg::REG_INV_Z) begin
			inv_reg[idx - plce_pkg::REG_INV_X] = val;
		end
	endtask

	task automatic setup(logic [4:0] bx, logic [4:0] by, logic [4:0] bz, logic [2:0] pm,
			logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
		write_reg(plce_pkg::REG_BINS_X, {27'b0, bx});
		write_reg(plce_pkg::REG_BINS_Y, {27'b0, by});
		write_reg(plce_pkg::REG_BINS_Z, {27'b0, bz});
		write_reg(plce_pkg::REG_PERIODIC, {29'b0, pm});
		write_reg(plce_pkg::REG_INV_X, ix);
		write_reg(plce_pkg::REG_INV_Y, iy);
		write_reg(plce_pkg::REG_INV_Z, iz);
	endtask

	task automatic push_item(logic [1:0] act, int tag, int px, int py, int pz);
		plce_pkg::in_item_t it;
		it.action = act;
		it.tag_id = plce_pkg::TAG_W'(tag);
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		pending_items = {pending_items, it};
	endtask

	function automatic int rand_pos(int span);
		if ($urandom_range(0, 9) == 0) return int'($urandom);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Position of bin 0, 1 or 2 along an axis of the three-bin grid.
	function automatic int grid3_pos(int d);
		if (d == 0) return -32'sh8000;
		if (d == 1) return 0;
		return 32'sh6000;
	endfunction

	// Random mix: mostly inserts and queries on a small tag pool.
	task automatic push_random(int count, int span);
		int r, tag;
		logic [1:0] act;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			act = (r < 50) ? plce_pkg::ACT_INSERT : (r < 67) ? plce_pkg::ACT_REMOVE
				: (r < 97) ? plce_pkg::ACT_QUERY : plce_pkg::ACT_CLEAR;
			tag = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
			push_item(act, tag, rand_pos(span), rand_pos(span), rand_pos(span));
		end
	endtask

	initial begin
		for (int a = 0; a < 3; a++) begin
			bins_reg[a] = 5'd16;
			inv_reg[a] = 32'h0010_0000;
		end
		wrap_mask = 3'd7;
		empty_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, top-edge wrap, a full bin, queries, removes and a clear.
		push_item(plce_pkg::ACT_INSERT, 0, 0, 0, 0);
		push_item(plce_pkg::ACT_INSERT, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_item(plce_pkg::ACT_INSERT, 5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_item(plce_pkg::ACT_INSERT, 6, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		for (int t = 10; t <= 17; t++) push_item(plce_pkg::ACT_INSERT, t, 0, 0, 0);
		push_item(plce_pkg::ACT_INSERT, 0, 32'h0000_1000, 0, 0);
		push_item(plce_pkg::ACT_QUERY, 10, 0, 0, 0);
		push_item(plce_pkg::ACT_QUERY, 1023, 0, 0, 0);
		push_item(plce_pkg::ACT_QUERY, 17, 0, 0, 0);
		push_item(plce_pkg::ACT_QUERY, 0, 0, 0, 0);
		push_item(plce_pkg::ACT_QUERY, 5, 0, 0, 0);
		push_item(plce_pkg::ACT_REMOVE, 11, 0, 0, 0);
		push_item(plce_pkg::ACT_REMOVE, 11, 0, 0, 0);
		push_item(plce_pkg::ACT_CLEAR, 0, 0, 0, 0);
		push_item(plce_pkg::ACT_QUERY, 10, 0, 0, 0);
		wait_idle();

		// A small dense grid: 66 tags over all 27 bins, then a truncated list.
		setup(5'd3, 5'd3, 5'd3, 3'd7, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		sender_bursty = 1'b1;
		stall_pct = 30;
		for (int k = 0; k < 66; k++)
			push_item(plce_pkg::ACT_INSERT, 100 + k, grid3_pos((k % 27) / 9),
				grid3_pos((k / 3) % 3), grid3_pos(k % 3));
		push_item(plce_pkg::ACT_QUERY, 113, 0, 0, 0);
		push_random(16, 32'h9000);
		wait_idle();

		// Saturated bin counts and extreme inverse widths.
		setup(5'd0, 5'd31, 5'd2, 3'd2, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
		stall_pct = 60;
		push_random(12, 32'h2_0000);
		wait_idle();

		// Full-size grid without a y wrap.
		setup(5'd16, 5'd16, 5'd16, 3'd5, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
		sender_bursty = 1'b0;
		stall_pct = 0;
		push_random(7, 32'h9000);
		wait_idle();
		setup(5'd1, 5'd16, 5'd4, 3'd0, 32'h0020_0000, 32'h0010_0000, 32'h0004_0000);
		sender_bursty = 1'b1;
		stall_pct = 20;
		push_random(7, 32'h9000);
		wait_idle();
		repeat (50) @(posedge clk);

		$display("Covered %0d actions and %0d result beats over five table settings,", items_sent,
			beats_seen);
		$display("including %0d full-bin inserts and %0d truncated lists.", full_bins,
			truncated_lists);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== particle_cell_list_engine.f =====
rtl/plce_pkg.sv
rtl/plce_axis.sv
rtl/plce_store.sv
rtl/plce_ctrl.sv
rtl/particle_cell_list_engine.sv
rtl/plce_checker.sv
verif/tb.sv
